// ===== src/vau_pkg.sv =====
// Shared constants and the arctangent step table for the vector angle unit.
`timescale 1ns / 1ps
`default_nettype none

package vau_pkg;

   localparam int COORD_BITS_DEF      = 32;
   localparam int ANGLE_FRAC_BITS_DEF = 16;

   // The largest normalized component magnitude of each vector lies in [2^29, 2^30).
   localparam int NORM_BITS    = 30;
   localparam int WORK_FRAC    = 30;
   localparam int ROOT_STEPS   = 31;
   localparam int CORDIC_STEPS = 31;
   localparam int CORDIC_BITS  = 34;

   localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
   localparam logic [31:0] PI_Q30      = 32'd3373259426;

   // atan(2^-idx) in Q30, rounded to nearest.
   function automatic logic [31:0] atan_q30(input int unsigned idx);
      logic [31:0] val;
      unique case (idx)
         0:  val = 32'd843314857;
         1:  val = 32'd497837829;
         2:  val = 32'd263043837;
         3:  val = 32'd133525159;
         4:  val = 32'd67021687;
         5:  val = 32'd33543516;
         6:  val = 32'd16775851;
         7:  val = 32'd8388437;
         8:  val = 32'd4194283;
         9:  val = 32'd2097149;
         default: val = 32'd1 << (30 - idx);
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== src/vau_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none

module vau_isqrt #(
   parameter int STEPS     = 31,
   parameter int LANES     = 1,
   parameter int SIDE_BITS = 1
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              in_valid,
   input  wire logic [LANES-1:0][2*STEPS-1:0]     in_value,
   input  wire logic [SIDE_BITS-1:0]              in_side,
   output logic                                   out_valid,
   output logic [LANES-1:0][STEPS-1:0]            out_root,
   output logic [SIDE_BITS-1:0]                   out_side
);

   localparam int W = 2 * STEPS;

   logic                            valid_ff [STEPS];
   logic [SIDE_BITS-1:0]            side_ff  [STEPS];
   logic [LANES-1:0][W-1:0]         rem_ff   [STEPS];
   logic [LANES-1:0][W-1:0]         res_ff   [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [W-1:0] Bit = {{(W-1){1'b0}}, 1'b1} << (2 * (STEPS - 1 - k));

      logic                    valid_src;
      logic [SIDE_BITS-1:0]    side_src;
      logic [LANES-1:0][W-1:0] rem_src;
      logic [LANES-1:0][W-1:0] res_src;
      logic [LANES-1:0][W-1:0] rem_in;
      logic [LANES-1:0][W-1:0] res_in;

      if (k == 0) begin : g_first
         assign valid_src = in_valid;
         assign side_src  = in_side;
         assign rem_src   = in_value;
         assign res_src   = '0;
      end else begin : g_next
         assign valid_src = valid_ff[k-1];
         assign side_src  = side_ff[k-1];
         assign rem_src   = rem_ff[k-1];
         assign res_src   = res_ff[k-1];
      end

      always_comb begin
         logic [W-1:0] trial;
         for (int n = 0; n < LANES; n++) begin
            trial = res_src[n] + Bit;
            if (rem_src[n] >= trial) begin
               rem_in[n] = rem_src[n] - trial;
               res_in[n] = (res_src[n] >> 1) + Bit;
            end else begin
               rem_in[n] = rem_src[n];
               res_in[n] = res_src[n] >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         side_ff[k] <= side_src;
         rem_ff[k]  <= rem_in;
         res_ff[k]  <= res_in;
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

   always_comb begin
      for (int n = 0; n < LANES; n++) begin
         out_root[n] = res_ff[STEPS-1][n][STEPS-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== src/vector_angle_unit_core.sv =====
// Top level of the vector angle unit: angle between two 3D vectors.
`timescale 1ns / 1ps
`default_nettype none

// Takes two 3D vectors (signed Q8.24 components) and returns the angle between
// them in radians as unsigned Q2.ANGLE_FRAC_BITS, 0 to pi, or a degenerate
// flag with angle 0 when either vector is zero. The unit is a fixed pipeline
// with no stall: busy stays low, a pair may be started in every cycle, and
// results appear on rsp_strobe in the order the pairs were started. The
// pipeline holds one register per stage: the normalize and
// dot-product front end (6), the length square root (31), the length multiply
// (1), the cosine divider (1 load plus 30 quotient bits), the cosine square
// (1), the sine square root (31), the CORDIC arctangent (1 load plus 31
// rotations) and the output register (1).
// Results must be taken in the cycle they are shown.
module vector_angle_unit_core #(
   parameter int COORD_BITS      = vau_pkg::COORD_BITS_DEF,
   parameter int ANGLE_FRAC_BITS = vau_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic signed [COORD_BITS-1:0]  req_first_x,
   input  wire logic signed [COORD_BITS-1:0]  req_first_y,
   input  wire logic signed [COORD_BITS-1:0]  req_first_z,
   input  wire logic signed [COORD_BITS-1:0]  req_second_x,
   input  wire logic signed [COORD_BITS-1:0]  req_second_y,
   input  wire logic signed [COORD_BITS-1:0]  req_second_z,
   output logic                               rsp_strobe,
   output logic [ANGLE_FRAC_BITS+1:0]         rsp_angle,
   output logic                               rsp_degenerate
);

   localparam int MW    = COORD_BITS;
   localparam int PW    = $clog2(COORD_BITS);
   localparam int NB    = vau_pkg::NORM_BITS;
   localparam int PB    = 2 * NB;
   localparam int SB    = PB + 2;
   localparam int RS    = vau_pkg::ROOT_STEPS;
   localparam int WF    = vau_pkg::WORK_FRAC;
   localparam int CB    = vau_pkg::CORDIC_BITS;
   localparam int CS    = vau_pkg::CORDIC_STEPS;
   localparam int AW    = ANGLE_FRAC_BITS + 2;
   localparam int SH    = WF - ANGLE_FRAC_BITS;

   assign busy = 1'b0;

   // ---------------- stage 1: sign and magnitude ----------------
   logic [MW-1:0] raw [6];
   assign raw[0] = req_first_x;
   assign raw[1] = req_first_y;
   assign raw[2] = req_first_z;
   assign raw[3] = req_second_x;
   assign raw[4] = req_second_y;
   assign raw[5] = req_second_z;

   logic          v1_ff;
   logic [MW-1:0] mag1_ff [6];
   logic          neg1_ff [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n < 6; n++) begin
         neg1_ff[n] <= raw[n][MW-1];
         mag1_ff[n] <= raw[n][MW-1] ? (~raw[n] + 1'b1) : raw[n];
      end
   end

   // ---------------- stage 2: zero check and leading one ----------------
   function automatic logic [PW-1:0] msb_pos(input logic [MW-1:0] m);
      logic [PW-1:0] p;
      p = '0;
      for (int i = 0; i < MW; i++) begin
         if (m[i]) p = PW'(i);
      end
      return p;
   endfunction

   logic          v2_ff;
   logic          deg2_ff;
   logic [MW-1:0] mag2_ff [6];
   logic          neg2_ff [6];
   logic [PW-1:0] pos2_ff [2];
   logic [MW-1:0] max_a;
   logic [MW-1:0] max_b;

   always_comb begin
      max_a = mag1_ff[0];
      if (mag1_ff[1] > max_a) max_a = mag1_ff[1];
      if (mag1_ff[2] > max_a) max_a = mag1_ff[2];
      max_b = mag1_ff[3];
      if (mag1_ff[4] > max_b) max_b = mag1_ff[4];
      if (mag1_ff[5] > max_b) max_b = mag1_ff[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      deg2_ff    <= (max_a == '0) || (max_b == '0);
      pos2_ff[0] <= msb_pos(max_a);
      pos2_ff[1] <= msb_pos(max_b);
      mag2_ff    <= mag1_ff;
      neg2_ff    <= neg1_ff;
   end

   // ---------------- stage 3: normalize, largest component to [2^29, 2^30) ----------------
   logic          v3_ff;
   logic          deg3_ff;
   logic [NB-1:0] norm3_ff [6];
   logic          neg3_ff  [6];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic [MW+NB-2:0] ext;
      for (int n = 0; n < 6; n++) begin
         ext = {mag2_ff[n], {(NB-1){1'b0}}} >> pos2_ff[n / 3];
         norm3_ff[n] <= ext[NB-1:0];
      end
      neg3_ff <= neg2_ff;
      deg3_ff <= deg2_ff;
   end

   // ---------------- stage 4: products ----------------
   logic          v4_ff;
   logic          deg4_ff;
   logic [PB-1:0] aa4_ff [3];
   logic [PB-1:0] bb4_ff [3];
   logic [PB-1:0] ab4_ff [3];
   logic          opp4_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int n = 0; n < 3; n++) begin
         aa4_ff[n]  <= norm3_ff[n] * norm3_ff[n];
         bb4_ff[n]  <= norm3_ff[n+3] * norm3_ff[n+3];
         ab4_ff[n]  <= norm3_ff[n] * norm3_ff[n+3];
         opp4_ff[n] <= neg3_ff[n] ^ neg3_ff[n+3];
      end
      deg4_ff <= deg3_ff;
   end

   // ---------------- stage 5: sums ----------------
   logic          v5_ff;
   logic          deg5_ff;
   logic [SB-1:0] a5_ff;
   logic [SB-1:0] b5_ff;
   logic [SB-1:0] pos5_ff;
   logic [SB-1:0] neg5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      logic [SB-1:0] p_sum;
      logic [SB-1:0] n_sum;
      p_sum = '0;
      n_sum = '0;
      for (int n = 0; n < 3; n++) begin
         if (opp4_ff[n]) n_sum = n_sum + SB'(ab4_ff[n]);
         else            p_sum = p_sum + SB'(ab4_ff[n]);
      end
      a5_ff   <= SB'(aa4_ff[0]) + SB'(aa4_ff[1]) + SB'(aa4_ff[2]);
      b5_ff   <= SB'(bb4_ff[0]) + SB'(bb4_ff[1]) + SB'(bb4_ff[2]);
      pos5_ff <= p_sum;
      neg5_ff <= n_sum;
      deg5_ff <= deg4_ff;
   end

   // ---------------- stage 6: dot product sign and magnitude ----------------
   logic          v6_ff;
   logic          deg6_ff;
   logic          dneg6_ff;
   logic [SB-1:0] dmag6_ff;
   logic [SB-1:0] a6_ff;
   logic [SB-1:0] b6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      dneg6_ff <= neg5_ff > pos5_ff;
      dmag6_ff <= (neg5_ff > pos5_ff) ? (neg5_ff - pos5_ff) : (pos5_ff - neg5_ff);
      a6_ff    <= a5_ff;
      b6_ff    <= b5_ff;
      deg6_ff  <= deg5_ff;
   end

   // ---------------- lengths ----------------
   localparam int LSIDE = SB + 2;

   logic                      len_valid;
   logic [1:0][RS-1:0]        len_root;
   logic [LSIDE-1:0]          len_side;

   vau_isqrt #(
      .STEPS     (RS),
      .LANES     (2),
      .SIDE_BITS (LSIDE)
   ) u_len_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v6_ff),
      .in_value  ({b6_ff, a6_ff}),
      .in_side   ({deg6_ff, dneg6_ff, dmag6_ff}),
      .out_valid (len_valid),
      .out_root  (len_root),
      .out_side  (len_side)
   );

   logic          vl_ff;
   logic          degl_ff;
   logic          dnegl_ff;
   logic [SB-1:0] dmagl_ff;
   logic [SB-1:0] lenl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff <= 1'b0;
      end else begin
         vl_ff <= len_valid;
      end
   end

   always_ff @(posedge clock) begin
      lenl_ff  <= SB'(len_root[0] * len_root[1]);
      degl_ff  <= len_side[SB+1];
      dnegl_ff <= len_side[SB];
      dmagl_ff <= len_side[SB-1:0];
   end

   // ---------------- cosine divider ----------------
   logic          dv_ff   [WF+1];
   logic          dsat_ff [WF+1];
   logic          ddeg_ff [WF+1];
   logic          dneg_ff [WF+1];
   logic [SB:0]   drem_ff [WF+1];
   logic [SB-1:0] dlen_ff [WF+1];
   logic [WF-1:0] dquo_ff [WF+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= vl_ff;
      end
   end

   always_ff @(posedge clock) begin
      dsat_ff[0] <= dmagl_ff >= lenl_ff;
      ddeg_ff[0] <= degl_ff;
      dneg_ff[0] <= dnegl_ff;
      drem_ff[0] <= {1'b0, dmagl_ff};
      dlen_ff[0] <= lenl_ff;
      dquo_ff[0] <= '0;
   end

   for (genvar k = 1; k <= WF; k++) begin : g_div
      logic [SB:0] shifted;
      logic        take;
      assign shifted = {drem_ff[k-1][SB-1:0], 1'b0};
      assign take    = shifted >= {1'b0, dlen_ff[k-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else begin
            dv_ff[k] <= dv_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         drem_ff[k] <= take ? (shifted - {1'b0, dlen_ff[k-1]}) : shifted;
         dquo_ff[k] <= {dquo_ff[k-1][WF-2:0], take};
         dlen_ff[k] <= dlen_ff[k-1];
         dsat_ff[k] <= dsat_ff[k-1];
         ddeg_ff[k] <= ddeg_ff[k-1];
         dneg_ff[k] <= dneg_ff[k-1];
      end
   end

   // ---------------- cosine square ----------------
   localparam logic [WF:0]     ONE_Q30 = {1'b1, {WF{1'b0}}};
   localparam logic [2*WF+1:0] ONE_SQ  = {2'b01, {(2*WF){1'b0}}};

   logic [WF:0] cos_mag;
   assign cos_mag = dsat_ff[WF] ? ONE_Q30 : {1'b0, dquo_ff[WF]};

   logic              vc_ff;
   logic              degc_ff;
   logic              cnegc_ff;
   logic [WF:0]       cmagc_ff;
   logic [2*WF+1:0]   sinsq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else begin
         vc_ff <= dv_ff[WF];
      end
   end

   always_ff @(posedge clock) begin
      sinsq_ff <= ONE_SQ - (2*WF+2)'(cos_mag * cos_mag);
      cmagc_ff <= cos_mag;
      cnegc_ff <= dneg_ff[WF] && (cos_mag != '0);
      degc_ff  <= ddeg_ff[WF];
   end

   // ---------------- sine ----------------
   localparam int SSIDE = WF + 3;

   logic                sin_valid;
   logic [0:0][RS-1:0]  sin_root;
   logic [SSIDE-1:0]    sin_side;

   vau_isqrt #(
      .STEPS     (RS),
      .LANES     (1),
      .SIDE_BITS (SSIDE)
   ) u_sin_root (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vc_ff),
      .in_value  (sinsq_ff),
      .in_side   ({degc_ff, cnegc_ff, cmagc_ff}),
      .out_valid (sin_valid),
      .out_root  (sin_root),
      .out_side  (sin_side)
   );

   // ---------------- CORDIC arctangent ----------------
   logic                 cv_ff   [CS+1];
   logic                 cdeg_ff [CS+1];
   logic signed [CB-1:0] cx_ff   [CS+1];
   logic signed [CB-1:0] cy_ff   [CS+1];
   logic signed [CB-1:0] cz_ff   [CS+1];

   logic signed [CB-1:0] sin_ext;
   logic signed [CB-1:0] cos_ext;
   assign sin_ext = $signed(CB'(sin_root[0]));
   assign cos_ext = $signed(CB'(sin_side[WF:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else begin
         cv_ff[0] <= sin_valid;
      end
   end

   // Negative cosine starts from a quarter turn with the axes swapped.
   always_ff @(posedge clock) begin
      cdeg_ff[0] <= sin_side[WF+2];
      if (sin_side[WF+1]) begin
         cx_ff[0] <= sin_ext;
         cy_ff[0] <= cos_ext;
         cz_ff[0] <= $signed(CB'(vau_pkg::HALF_PI_Q30));
      end else begin
         cx_ff[0] <= cos_ext;
         cy_ff[0] <= sin_ext;
         cz_ff[0] <= '0;
      end
   end

   for (genvar k = 0; k < CS; k++) begin : g_cordic
      localparam logic signed [CB-1:0] Step = $signed(CB'(vau_pkg::atan_q30(k)));
      logic signed [CB-1:0] xs;
      logic signed [CB-1:0] ys;
      assign xs = cx_ff[k] >>> k;
      assign ys = cy_ff[k] >>> k;

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[k+1] <= 1'b0;
         end else begin
            cv_ff[k+1] <= cv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         cdeg_ff[k+1] <= cdeg_ff[k];
         if (!cy_ff[k][CB-1]) begin
            cx_ff[k+1] <= cx_ff[k] + ys;
            cy_ff[k+1] <= cy_ff[k] - xs;
            cz_ff[k+1] <= cz_ff[k] + Step;
         end else begin
            cx_ff[k+1] <= cx_ff[k] - ys;
            cy_ff[k+1] <= cy_ff[k] + xs;
            cz_ff[k+1] <= cz_ff[k] - Step;
         end
      end
   end

   // ---------------- clamp, round, result ----------------
   localparam logic signed [CB-1:0] PI_EXT = $signed(CB'(vau_pkg::PI_Q30));

   logic [31:0] z_clamped;
   logic [32:0] z_round;

   always_comb begin
      if (cz_ff[CS] < 0) begin
         z_clamped = '0;
      end else if (cz_ff[CS] > PI_EXT) begin
         z_clamped = vau_pkg::PI_Q30;
      end else begin
         z_clamped = cz_ff[CS][31:0];
      end
   end

   if (SH > 0) begin : g_round
      logic [32:0] half;
      assign half    = 33'd1 << (SH - 1);
      assign z_round = ({1'b0, z_clamped} + half) >> SH;
   end else begin : g_exact
      assign z_round = {1'b0, z_clamped};
   end

   logic          rsp_strobe_ff;
   logic [AW-1:0] rsp_angle_ff;
   logic          rsp_degenerate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cv_ff[CS];
      end
   end

   always_ff @(posedge clock) begin
      rsp_degenerate_ff <= cdeg_ff[CS];
      rsp_angle_ff      <= cdeg_ff[CS] ? '0 : z_round[AW-1:0];
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_angle      = rsp_angle_ff;
   assign rsp_degenerate = rsp_degenerate_ff;

endmodule

`default_nettype wire

// ===== dv/tb_vector_angle_unit_core.sv =====
// Self-checking testbench for vector_angle_unit_core: random and directed vector pairs.
`timescale 1ns / 1ps

module tb_vector_angle_unit_core;

   localparam int CB        = vau_pkg::COORD_BITS_DEF;
   localparam int AFB       = vau_pkg::ANGLE_FRAC_BITS_DEF;
   localparam int LATENCY   = 134;
   localparam int N_RANDOM  = 1730;
   localparam int CALM_TAIL = 200;

   typedef struct {
      logic signed [CB-1:0] ax, ay, az, bx, by, bz;
   } vec_pair_type;

   typedef struct {
      logic [AFB+1:0] angle;
      logic           degenerate;
   } angle_res_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [CB-1:0] req_first_x = '0, req_first_y = '0, req_first_z = '0;
   logic signed [CB-1:0] req_second_x = '0, req_second_y = '0, req_second_z = '0;
   logic                 rsp_strobe;
   logic [AFB+1:0]       rsp_angle;
   logic                 rsp_degenerate;

   vec_pair_type  pending_pairs[$];
   angle_res_type expected_angles[$];
   int            n_errors = 0;
   int            n_left_to_send = 0;
   logic [63:0] atan_tab [vau_pkg::CORDIC_STEPS];
   logic [63:0] quarter_pi_q62;

   vector_angle_unit_core dut (
      .clock, .reset, .start, .busy,
      .req_first_x, .req_first_y, .req_first_z,
      .req_second_x, .req_second_y, .req_second_z,
      .rsp_strobe, .rsp_angle, .rsp_degenerate
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // atan(1/q) in Q62 by the alternating series
   function automatic logic [63:0] atan_inv_q62(input logic [63:0] q);
      logic [63:0] p, q2, sum, n;
      bit add;
      p = (64'd1 << 62) / q;
      q2 = q * q;
      sum = 0;
      n = 1;
      add = 1;
      while (p != 0) begin
         if (add) sum = sum + p / n;
         else     sum = sum - p / n;
         add = !add;
         p = p / q2;
         n = n + 2;
      end
      return sum;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // scale magnitudes so the largest lies in [2^29, 2^30)
   function automatic void normalize(ref logic [63:0] m [3]);
      logic [63:0] top;
      int rs, ls;
      top = m[0];
      rs = 0;
      ls = 0;
      if (m[1] > top) top = m[1];
      if (m[2] > top) top = m[2];
      while (top >= (64'd1 << 30)) begin top = top >> 1; rs++; end
      while (top < (64'd1 << 29)) begin top = top << 1; ls++; end
      for (int k = 0; k < 3; k++) m[k] = (m[k] >> rs) << ls;
   endfunction

   function automatic angle_res_type predict_angle(input vec_pair_type v);
      angle_res_type r;
      logic signed [CB-1:0] raw [6];
      logic [63:0] am [3], bm [3];
      bit an [3], bn [3];
      logic [63:0] sum_a, sum_b, pos, neg, dmag, len, cmag, rem, s, ang, half_pi, pi;
      bit dneg, c_neg;
      longint x, y, z, nx, ny;
      raw = '{v.ax, v.ay, v.az, v.bx, v.by, v.bz};
      for (int k = 0; k < 3; k++) begin
         an[k] = raw[k][CB-1];
         bn[k] = raw[k+3][CB-1];
         am[k] = an[k] ? {32'd0, -raw[k]} : {32'd0, raw[k]};
         bm[k] = bn[k] ? {32'd0, -raw[k+3]} : {32'd0, raw[k+3]};
      end
      r.angle = '0;
      r.degenerate = 1'b0;
      if ((am[0] | am[1] | am[2]) == 0 || (bm[0] | bm[1] | bm[2]) == 0) begin
         r.degenerate = 1'b1;
         return r;
      end
      normalize(am);
      normalize(bm);
      sum_a = 0; sum_b = 0; pos = 0; neg = 0;
      for (int k = 0; k < 3; k++) begin
         sum_a += am[k] * am[k];
         sum_b += bm[k] * bm[k];
         if (an[k] != bn[k]) neg += am[k] * bm[k];
         else                pos += am[k] * bm[k];
      end
      dneg = neg > pos;
      dmag = dneg ? neg - pos : pos - neg;
      len = int_sqrt(sum_a) * int_sqrt(sum_b);
      if (dmag >= len) begin
         cmag = 64'd1 << vau_pkg::WORK_FRAC;
      end else begin
         rem = dmag;
         cmag = 0;
         for (int k = 0; k < vau_pkg::WORK_FRAC; k++) begin
            rem = rem << 1;
            cmag = cmag << 1;
            if (rem >= len) begin rem = rem - len; cmag[0] = 1'b1; end
         end
      end
      c_neg = dneg && cmag != 0;
      s = int_sqrt((64'd1 << (2 * vau_pkg::WORK_FRAC)) - cmag * cmag);
      half_pi = (2 * quarter_pi_q62 + (64'd1 << 31)) >> 32;
      pi = (4 * quarter_pi_q62 + (64'd1 << 31)) >> 32;
      if (c_neg) begin
         x = s; y = cmag; z = half_pi;
      end else begin
         x = cmag; y = s; z = 0;
      end
      for (int k = 0; k < vau_pkg::CORDIC_STEPS; k++) begin
         if (y >= 0) begin
            nx = x + (y >>> k);
            ny = y - (x >>> k);
            z = z + longint'(atan_tab[k]);
         end else begin
            nx = x - (y >>> k);
            ny = y + (x >>> k);
            z = z - longint'(atan_tab[k]);
         end
         x = nx;
         y = ny;
      end
      if (z < 0) z = 0;
      if (z > longint'(pi)) z = pi;
      ang = (64'(z) + (64'd1 << (vau_pkg::WORK_FRAC - AFB - 1))) >> (vau_pkg::WORK_FRAC - AFB);
      r.angle = ang[AFB+1:0];
      return r;
   endfunction

   function automatic logic signed [CB-1:0] rand_coord(input int kind);
      case (kind)
         0:       return $urandom();
         1:       return $signed(CB'($urandom_range(0, 16))) - 8;
         2:       return $signed($urandom()) >>> $urandom_range(0, 31);
         default: return '0;
      endcase
   endfunction

   // driver
   int idle_left = 0;
   always @(posedge clock) begin
      vec_pair_type nxt;
      bit           go;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_angles = {expected_angles,
                               predict_angle('{req_first_x, req_first_y, req_first_z,
                                               req_second_x, req_second_y,
                                               req_second_z})};
            n_left_to_send--;
         end
         go = 1'b0;
         if (!(start && busy)) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (pending_pairs.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
               idle_left = $urandom_range(0, 13);
            end else if (pending_pairs.size() > 0) begin
               nxt = pending_pairs.pop_front();
               req_first_x  <= nxt.ax;
               req_first_y  <= nxt.ay;
               req_first_z  <= nxt.az;
               req_second_x <= nxt.bx;
               req_second_y <= nxt.by;
               req_second_z <= nxt.bz;
               go = 1'b1;
            end
            start <= go;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      angle_res_type want;
      if (!reset && rsp_strobe) begin
         if (expected_angles.size() == 0) begin
            $display("%0t: unexpected result angle=%0d degenerate=%0b",
                     $time, rsp_angle, rsp_degenerate);
            n_errors++;
         end else begin
            want = expected_angles.pop_front();
            if (rsp_angle !== want.angle) begin
               $display("%0t: angle mismatch expected %0d actual %0d",
                        $time, want.angle, rsp_angle);
               n_errors++;
            end
            if (rsp_degenerate !== want.degenerate) begin
               $display("%0t: degenerate mismatch expected %0b actual %0b",
                        $time, want.degenerate, rsp_degenerate);
               n_errors++;
            end
         end
      end
   end

   function automatic void add_pair(input logic signed [CB-1:0] ax, ay, az, bx, by, bz);
      pending_pairs = {pending_pairs, vec_pair_type'{ax, ay, az, bx, by, bz}};
      n_left_to_send++;
   endfunction

   initial begin
      localparam logic signed [CB-1:0] MAXV = {1'b0, {(CB-1){1'b1}}};
      localparam logic signed [CB-1:0] MINV = {1'b1, {(CB-1){1'b0}}};
      localparam logic signed [CB-1:0] ONE  = 1 << 24;
      logic signed [CB-1:0] c [6];
      int kind;
      int side;
      quarter_pi_q62 = atan_inv_q62(2) + atan_inv_q62(3);
      atan_tab[0] = (quarter_pi_q62 + (64'd1 << 31)) >> 32;
      for (int i = 1; i < vau_pkg::CORDIC_STEPS; i++)
         atan_tab[i] = (atan_inv_q62(64'd1 << i) + (64'd1 << 31)) >> 32;

      // zero vectors, extremes, parallel, opposite, orthogonal
      add_pair(0, 0, 0, ONE, 0, 0);
      add_pair(ONE, 0, 0, 0, 0, 0);
      add_pair(0, 0, 0, 0, 0, 0);
      add_pair(ONE, 0, 0, ONE, 0, 0);
      add_pair(ONE, 0, 0, -ONE, 0, 0);
      add_pair(ONE, 0, 0, 0, ONE, 0);
      add_pair(0, 0, ONE, 0, ONE, 0);
      add_pair(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
      add_pair(MINV, MINV, MINV, MINV, MINV, MINV);
      add_pair(MAXV, MAXV, MAXV, MINV, MINV, MINV);
      add_pair(MINV, 0, 0, MAXV, 0, 0);
      add_pair(MINV, MAXV, 0, 1, 1, 0);
      add_pair(1, 0, 0, MAXV, 0, 0);
      add_pair(1, 1, 1, -1, -1, -1);
      add_pair(1, 0, 0, 0, 0, -1);
      add_pair(-1, -1, 0, MINV, MINV, 0);
      add_pair(MAXV, 1, 0, MAXV, -1, 0);
      add_pair(ONE, ONE, 0, ONE, ONE - 1, 0);
      add_pair(ONE, 2, 3, -ONE, -2, -3);
      add_pair(3, 4, 0, 4, -3, 0);
      for (int n = 0; n < N_RANDOM; n++) begin
         kind = $urandom_range(0, 9);
         for (int k = 0; k < 6; k++) c[k] = rand_coord(kind < 5 ? 0 : kind < 7 ? 2 : 1);
         if (kind == 7) begin
            // second vector: each first component, negated at random, plus small noise
            for (int k = 0; k < 3; k++)
               c[k+3] = ($urandom_range(0, 1) ? c[k] : -c[k]) + rand_coord(1);
         end else if (kind == 8 && $urandom_range(0, 3) == 0) begin
            // zero one whole vector
            side = $urandom_range(0, 1) * 3;
            for (int k = 0; k < 3; k++) c[side + k] = '0;
         end
         add_pair(c[0], c[1], c[2], c[3], c[4], c[5]);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      while (n_left_to_send > 0 || expected_angles.size() > 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (n_errors == 0) $display("** vector_angle_unit_core: PASSED **");
      else               $display("** vector_angle_unit_core: FAILED **");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("** vector_angle_unit_core: FAILED **");
      $finish;
   end

endmodule

// ===== files.f =====
src/vau_pkg.sv
src/vau_isqrt.sv
src/vector_angle_unit_core.sv
dv/tb_vector_angle_unit_core.sv
